@@ hw/rtl/sprite_sheet_quad_generator_assert.svh @@
// assertion macros shared by the sprite sheet quad generator rtl
// relies on clk and rst_n being visible in the scope of use
`ifndef SPRITE_SHEET_QUAD_GENERATOR_ASSERT_SVH
`define SPRITE_SHEET_QUAD_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SSQG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SSQG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ssqg_pkg.sv @@
// shared types, constants and helpers for the sprite sheet quad generator
// no dependencies
package ssqg_pkg;

  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int TEX_W      = 17;
  localparam int VNUM_W     = 3;
  localparam int FRAC_LANES = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = CFG_IDX_W'(1);

  // vertex order of the two triangles
  typedef enum logic [VNUM_W-1:0] {
    VTX_TR0 = 3'd0,
    VTX_TL  = 3'd1,
    VTX_BL0 = 3'd2,
    VTX_TR1 = 3'd3,
    VTX_BL1 = 3'd4,
    VTX_BR  = 3'd5
  } vtx_sel_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [31:0]        frame;
    logic               mirror;
  } quad_in_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic [VNUM_W-1:0]  vertex_number;
    logic               last_vertex;
  } vertex_out_t;

  // quad corner positions plus mirror flag
  typedef struct packed {
    logic signed [31:0] x_left;
    logic signed [31:0] x_right;
    logic signed [31:0] y_top;
    logic signed [31:0] y_bot;
    logic               mirror;
  } quad_pos_t;

  // saturating 32-bit add or subtract
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b, logic sub);
    logic [32:0] s;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

endpackage

@@ hw/rtl/ssqg_rem_div.sv @@
// pipelined restoring divider, one quotient bit per register stage
// uses ssqg_pkg; sideband bits travel alongside each transaction
module ssqg_rem_div
  import ssqg_pkg::*;
#(
  parameter int NW = 32,
  parameter int DW = 18,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_dividend,
  input  logic [DW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic [DW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [DW-1:0] div_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          vld_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] div_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic          take;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign num_in  = in_dividend;
      assign quo_in  = '0;
      assign rem_in  = '0;
      assign div_in  = in_divisor;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign num_in  = num_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign div_in  = div_r[i-1];
      assign side_in = side_r[i-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign trial = {rem_in, num_in[NW-1]};
    assign take  = (trial >= {1'b0, div_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      num_r[i]  <= num_in << 1;
      quo_r[i]  <= {quo_in[NW-2:0], take};
      rem_r[i]  <= take ? DW'(trial - {1'b0, div_in}) : DW'(trial);
      div_r[i]  <= div_in;
      side_r[i] <= side_in;
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quot  = quo_r[NW-1];
  assign out_rem   = rem_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

@@ hw/rtl/ssqg_frac_div.sv @@
// pipelined fraction divider: floor(n * 2^(QW-1) / d) for n <= d, four lanes
// uses ssqg_pkg for the lane count; one quotient bit per register stage
module ssqg_frac_div
  import ssqg_pkg::*;
#(
  parameter int GW = 9,
  parameter int QW = 17,
  parameter int SW = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [FRAC_LANES-1:0][GW-1:0]   in_num,
  input  logic [FRAC_LANES-1:0][GW-1:0]   in_den,
  input  logic [SW-1:0]                   in_side,
  output logic                            out_valid,
  output logic [FRAC_LANES-1:0][QW-1:0]   out_quot,
  output logic [SW-1:0]                   out_side
);

  logic                          vld_r  [QW];
  logic [FRAC_LANES-1:0][GW-1:0] rem_r  [QW];
  logic [FRAC_LANES-1:0][GW-1:0] den_r  [QW];
  logic [FRAC_LANES-1:0][QW-1:0] quo_r  [QW];
  logic [SW-1:0]                 side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic                          vld_in;
    logic [FRAC_LANES-1:0][GW-1:0] rem_in;
    logic [FRAC_LANES-1:0][GW-1:0] den_in;
    logic [FRAC_LANES-1:0][QW-1:0] quo_in;
    logic [SW-1:0]                 side_in;
    logic [FRAC_LANES-1:0][GW:0]   trial;
    logic [FRAC_LANES-1:0]         take;
    logic [FRAC_LANES-1:0][GW-1:0] rem_nxt;
    logic [FRAC_LANES-1:0][QW-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
    end

    // first stage yields the integer bit, later stages shift in zeros
    always_comb begin
      for (int l = 0; l < FRAC_LANES; l++) begin
        trial[l]   = (i == 0) ? {1'b0, rem_in[l]} : {rem_in[l], 1'b0};
        take[l]    = (trial[l] >= {1'b0, den_in[l]});
        rem_nxt[l] = take[l] ? GW'(trial[l] - {1'b0, den_in[l]}) : GW'(trial[l]);
        quo_nxt[l] = {quo_in[l][QW-2:0], take[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= rem_nxt;
      den_r[i]  <= den_in;
      quo_r[i]  <= quo_nxt;
      side_r[i] <= side_in;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

@@ hw/rtl/ssqg_vtx_emit.sv @@
// vertex sequencer: holds one finished quad and sends its six vertices
// uses ssqg_pkg for the vertex order and the result struct
module ssqg_vtx_emit
  import ssqg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             quad_valid,
  input  quad_pos_t        quad_pos,
  input  logic [TEX_W-1:0] u_left,
  input  logic [TEX_W-1:0] u_right,
  input  logic [TEX_W-1:0] v_top,
  input  logic [TEX_W-1:0] v_bot,
  output logic             out_valid,
  output vertex_out_t      out_data
);

  quad_pos_t        pos_r;
  logic [TEX_W-1:0] ul_r, ur_r, vt_r, vb_r;
  logic             active_r, active_nxt;
  vtx_sel_t         cnt_r, cnt_nxt;
  logic             out_valid_r;
  vertex_out_t      out_data_r;
  vertex_out_t      vtx;

  // quad hold registers
  always_ff @(posedge clk) begin
    if (quad_valid) begin
      pos_r <= quad_pos;
      ul_r  <= u_left;
      ur_r  <= u_right;
      vt_r  <= v_top;
      vb_r  <= v_bot;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= VTX_TR0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // next vertex, a new quad restarts the sequence
  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    if (quad_valid) begin
      active_nxt = 1'b1;
      cnt_nxt    = VTX_TR0;
    end else if (active_r) begin
      if (cnt_r == VTX_BR) begin
        active_nxt = 1'b0;
        cnt_nxt    = VTX_TR0;
      end else begin
        cnt_nxt = vtx_sel_t'(cnt_r + VNUM_W'(1));
      end
    end
  end

  // corner select for the current vertex
  always_comb begin
    vtx               = '0;
    vtx.vertex_number = cnt_r;
    vtx.last_vertex   = (cnt_r == VTX_BR);
    case (cnt_r) inside
      VTX_TR0, VTX_TR1: begin
        vtx.vert_x = pos_r.x_right;
        vtx.vert_y = pos_r.y_top;
        vtx.tex_u  = ur_r;
        vtx.tex_v  = vt_r;
      end
      VTX_TL: begin
        vtx.vert_x = pos_r.x_left;
        vtx.vert_y = pos_r.y_top;
        vtx.tex_u  = ul_r;
        vtx.tex_v  = vt_r;
      end
      VTX_BL0, VTX_BL1: begin
        vtx.vert_x = pos_r.x_left;
        vtx.vert_y = pos_r.y_bot;
        vtx.tex_u  = ul_r;
        vtx.tex_v  = vb_r;
      end
      VTX_BR: begin
        vtx.vert_x = pos_r.x_right;
        vtx.vert_y = pos_r.y_bot;
        vtx.tex_u  = ur_r;
        vtx.tex_v  = vb_r;
      end
      default: begin
        vtx.vert_x = '0;
      end
    endcase
  end

  // registered result port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= vtx;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/sprite_sheet_quad_generator.sv @@
// sprite sheet quad generator top level: config registers, front stages, dividers, emitter
// uses ssqg_pkg, ssqg_rem_div, ssqg_frac_div, ssqg_vtx_emit and the assert macro header
// pipeline: stages a and b, the bit-per-stage divider pipelines, then the emitter;
//   six vertices of each quad follow back to back
// throughput: start is taken only while busy is low, one vertex per cycle on the result port
// reset: synchronous, clears valid bits and the sequencer, grid registers return to 1
`include "sprite_sheet_quad_generator_assert.svh"

module sprite_sheet_quad_generator
  import ssqg_pkg::*;
#(
  parameter int UV_FRAC_BITS = 16,
  parameter int GRID_MAX     = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  quad_in_t             in_data,
  output logic                 out_valid,
  output vertex_out_t          out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int GW = $clog2(GRID_MAX + 1);
  localparam int DW = 2 * GW;
  localparam int QW = UV_FRAC_BITS + 1;
  localparam logic [QW-1:0] UV_ONE = QW'(1) << UV_FRAC_BITS;

  typedef struct packed {
    quad_pos_t     pos;
    logic [GW-1:0] cols;
    logic [GW-1:0] rows;
  } grid_side_t;

  localparam int SIDE_W = $bits(grid_side_t);
  localparam int POS_W  = $bits(quad_pos_t);

  // clamp a grid register to 1..GRID_MAX
  function automatic logic [GW-1:0] eff_grid(logic [CFG_W-1:0] r);
    int v;
    v = int'(r);
    if (v == 0) begin
      v = 1;
    end else if (v > GRID_MAX) begin
      v = GRID_MAX;
    end
    return GW'(v);
  endfunction

  logic [CFG_W-1:0] grid_columns_r, grid_rows_r;
  logic [2:0]       gap_r;
  logic             accept;

  logic             vld_a_r;
  quad_in_t         data_a_r;

  logic             vld_b_r;
  quad_pos_t        pos_b_r;
  logic [31:0]      frame_b_r;
  logic [GW-1:0]    cols_b_r, rows_b_r;
  logic [DW-1:0]    cells_b_r;

  logic [31:0]      a_half_x, a_half_y;

  logic             d1_valid;
  logic [DW-1:0]    d1_rem;
  logic [SIDE_W-1:0] d1_side;
  grid_side_t       d1_grid;

  logic             d2_valid;
  logic [DW-1:0]    d2_quot;
  logic [GW-1:0]    d2_rem;
  logic [SIDE_W-1:0] d2_side;
  grid_side_t       d2_grid;

  logic [FRAC_LANES-1:0][GW-1:0] fr_num, fr_den;
  logic             fr_valid;
  logic [FRAC_LANES-1:0][QW-1:0] fr_quot;
  logic [POS_W-1:0] fr_side;
  quad_pos_t        fr_pos;

  logic [QW-1:0]    uv_left, uv_right, uv_top, uv_bot;
  logic [TEX_W-1:0] tx_left, tx_right, tx_top, tx_bot;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= CFG_W'(1);
      grid_rows_r    <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_COLUMNS: grid_columns_r <= cfg_wdata;
        CFG_GRID_ROWS:    grid_rows_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // spacing counter, holds busy after each accepted transaction
  assign accept = start && !busy;
  assign busy   = (gap_r != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 3'd0;
    end else if (accept) begin
      gap_r <= 3'd5;
    end else if (gap_r != 3'd0) begin
      gap_r <= gap_r - 3'd1;
    end
  end

  // stage a: capture transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_a_r <= in_data;
    end
  end

  // stage b: corner positions and cell count
  assign a_half_x = {data_a_r.size_x[31], data_a_r.size_x[31:1]};
  assign a_half_y = {data_a_r.size_y[31], data_a_r.size_y[31:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    pos_b_r.x_left  <= sat_add(data_a_r.center_x, a_half_x, 1'b1);
    pos_b_r.x_right <= sat_add(data_a_r.center_x, a_half_x, 1'b0);
    pos_b_r.y_top   <= sat_add(data_a_r.center_y, a_half_y, 1'b0);
    pos_b_r.y_bot   <= sat_add(data_a_r.center_y, a_half_y, 1'b1);
    pos_b_r.mirror  <= data_a_r.mirror;
    frame_b_r       <= data_a_r.frame;
    cols_b_r        <= eff_grid(grid_columns_r);
    rows_b_r        <= eff_grid(grid_rows_r);
    cells_b_r       <= DW'(eff_grid(grid_columns_r)) * DW'(eff_grid(grid_rows_r));
  end

  // frame modulo cell count
  ssqg_rem_div #(.NW(32), .DW(DW), .SW(SIDE_W)) u_frame_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (vld_b_r),
    .in_dividend (frame_b_r),
    .in_divisor  (cells_b_r),
    .in_side     ({pos_b_r, cols_b_r, rows_b_r}),
    .out_valid   (d1_valid),
    .out_quot    (),
    .out_rem     (d1_rem),
    .out_side    (d1_side)
  );

  assign d1_grid = grid_side_t'(d1_side);

  // split cell index into row and column
  ssqg_rem_div #(.NW(DW), .DW(GW), .SW(SIDE_W)) u_cell_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (d1_valid),
    .in_dividend (d1_rem),
    .in_divisor  (d1_grid.cols),
    .in_side     (d1_side),
    .out_valid   (d2_valid),
    .out_quot    (d2_quot),
    .out_rem     (d2_rem),
    .out_side    (d2_side)
  );

  assign d2_grid = grid_side_t'(d2_side);

  // cell edges over grid size, lanes: u left, u right, v top, v bottom
  assign fr_num[0] = d2_rem;
  assign fr_num[1] = d2_rem + GW'(1);
  assign fr_num[2] = d2_quot[GW-1:0];
  assign fr_num[3] = d2_quot[GW-1:0] + GW'(1);
  assign fr_den[0] = d2_grid.cols;
  assign fr_den[1] = d2_grid.cols;
  assign fr_den[2] = d2_grid.rows;
  assign fr_den[3] = d2_grid.rows;

  ssqg_frac_div #(.GW(GW), .QW(QW), .SW(POS_W)) u_uv_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d2_valid),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .in_side   (d2_grid.pos),
    .out_valid (fr_valid),
    .out_quot  (fr_quot),
    .out_side  (fr_side)
  );

  assign fr_pos = quad_pos_t'(fr_side);

  // v runs downward from one, mirror swaps u
  assign uv_left  = fr_pos.mirror ? fr_quot[1] : fr_quot[0];
  assign uv_right = fr_pos.mirror ? fr_quot[0] : fr_quot[1];
  assign uv_top   = UV_ONE - fr_quot[2];
  assign uv_bot   = UV_ONE - fr_quot[3];

  assign tx_left  = TEX_W'(uv_left);
  assign tx_right = TEX_W'(uv_right);
  assign tx_top   = TEX_W'(uv_top);
  assign tx_bot   = TEX_W'(uv_bot);

  ssqg_vtx_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .quad_valid (fr_valid),
    .quad_pos   (fr_pos),
    .u_left     (tx_left),
    .u_right    (tx_right),
    .v_top      (tx_top),
    .v_bot      (tx_bot),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // checks
  `SSQG_ASSERT_NXT(a_busy_after_accept, start && !busy, busy, "busy not raised after accept")
  `SSQG_ASSERT_NXT(a_tl_follows_tr, out_valid && (out_data.vertex_number == VTX_TR0), out_valid && (out_data.vertex_number == VTX_TL), "vertex sequence broken after first vertex")
  `SSQG_ASSERT_NXT(a_restart_after_last, out_valid && out_data.last_vertex, !out_valid || (out_data.vertex_number == VTX_TR0), "quad overlapped after last vertex")
  `SSQG_ASSERT_IMP(a_last_is_br, out_valid && out_data.last_vertex, out_data.vertex_number == VTX_BR, "last flag on wrong vertex")

endmodule

@@ sim/sprite_sheet_quad_generator_test.sv @@
`timescale 1ns / 1ps
// testbench for sprite_sheet_quad_generator: directed and random sprite quads
// depends on ssqg_pkg and the block rtl; every vertex is checked against a local model
module sprite_sheet_quad_generator_test;
  import ssqg_pkg::*;

  localparam longint unsigned UV_ONE     = 64'd1 << 16;
  localparam longint unsigned GRID_LIMIT = 256;
  localparam longint          POS_MAX    = 64'sd2147483647;
  localparam longint          NEG_MIN    = -64'sd2147483648;
  localparam int              TAIL_CYCLES = 80;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_3 = CFG_IDX_W'(3);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  quad_in_t             in_data = '0;
  logic                 out_valid;
  vertex_out_t          out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  vertex_out_t      pending_vertices[$];
  vertex_out_t      want;
  logic [CFG_W-1:0] columns_reg = 1;
  logic [CFG_W-1:0] rows_reg = 1;
  int               max_gap = 5;
  int               errors = 0;
  int               quads_sent = 0;
  int               vertices_seen = 0;
  int               grid_writes = 0;

  always #5 clk = ~clk;

  sprite_sheet_quad_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register value as the block uses it
  function automatic longint unsigned grid_size(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > GRID_LIMIT) return GRID_LIMIT;
    return r;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > POS_MAX) return 32'h7fff_ffff;
    if (v < NEG_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic vertex_out_t make_vertex(vtx_sel_t k, longint x, longint y,
                                              longint unsigned u, longint unsigned v);
    vertex_out_t r;
    r.vert_x        = clamp32(x);
    r.vert_y        = clamp32(y);
    r.tex_u         = u[TEX_W-1:0];
    r.tex_v         = v[TEX_W-1:0];
    r.vertex_number = k;
    r.last_vertex   = (k == VTX_BR);
    return r;
  endfunction

  // six vertices of one sprite quad, queued in emit order
  task automatic predict_vertices(input quad_in_t q);
    longint unsigned cols, rows, f, col, row, u_l, u_r, v_t, v_b, t;
    longint          cx, cy, hx, hy, xl, xr, yt, yb;
    cols = grid_size(columns_reg);
    rows = grid_size(rows_reg);
    f    = q.frame;
    f    = f % (cols * rows);
    col  = f % cols;
    row  = f / cols;
    u_l  = (col * UV_ONE) / cols;
    u_r  = ((col + 1) * UV_ONE) / cols;
    v_t  = UV_ONE - (row * UV_ONE) / rows;
    v_b  = UV_ONE - ((row + 1) * UV_ONE) / rows;
    cx   = $signed(q.center_x);
    cy   = $signed(q.center_y);
    hx   = $signed(q.size_x) >>> 1;
    hy   = $signed(q.size_y) >>> 1;
    xl   = cx - hx;
    xr   = cx + hx;
    yt   = cy + hy;
    yb   = cy - hy;
    if (q.mirror) begin
      t   = u_l;
      u_l = u_r;
      u_r = t;
    end
    pending_vertices.push_back(make_vertex(VTX_TR0, xr, yt, u_r, v_t));
    pending_vertices.push_back(make_vertex(VTX_TL,  xl, yt, u_l, v_t));
    pending_vertices.push_back(make_vertex(VTX_BL0, xl, yb, u_l, v_b));
    pending_vertices.push_back(make_vertex(VTX_TR1, xr, yt, u_r, v_t));
    pending_vertices.push_back(make_vertex(VTX_BL1, xl, yb, u_l, v_b));
    pending_vertices.push_back(make_vertex(VTX_BR,  xr, yb, u_r, v_b));
  endtask

  function automatic void compare_field(string name, logic [31:0] exp_val,
                                        logic [31:0] got_val);
    if (exp_val !== got_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
    end
  endfunction

  // result checker, one vertex per strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        errors++;
        $display("%0t: vertex with none expected, expected nothing, actual %h",
                 $time, out_data);
      end else begin
        want = pending_vertices.pop_front();
        compare_field("vert_x", want.vert_x, out_data.vert_x);
        compare_field("vert_y", want.vert_y, out_data.vert_y);
        compare_field("tex_u", 32'(want.tex_u), 32'(out_data.tex_u));
        compare_field("tex_v", 32'(want.tex_v), 32'(out_data.tex_v));
        compare_field("vertex_number", 32'(want.vertex_number),
                      32'(out_data.vertex_number));
        compare_field("last_vertex", 32'(want.last_vertex), 32'(out_data.last_vertex));
      end
    end
  end

  // one transaction on the input channel after a random gap
  task automatic send_quad(input quad_in_t q);
    int gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (busy);
    predict_vertices(q);
    quads_sent++;
  endtask

  // lets every outstanding vertex come back
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_grid(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_COLUMNS) columns_reg = val;
    else if (idx == CFG_GRID_ROWS) rows_reg = val;
    grid_writes++;
  endtask

  function automatic quad_in_t make_quad(logic [31:0] cx, logic [31:0] cy, logic [31:0] sx,
                                         logic [31:0] sy, logic [31:0] fr, logic mir);
    quad_in_t q;
    q.center_x = cx;
    q.center_y = cy;
    q.size_x   = sx;
    q.size_y   = sy;
    q.frame    = fr;
    q.mirror   = mir;
    return q;
  endfunction

  // mix of full range, near the rails and small screen-like values
  function automatic logic [31:0] random_fixed();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return {($urandom_range(0, 1) ? 16'h7fff : 16'h8000), 16'($urandom)};
      default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endcase
  endfunction

  function automatic quad_in_t random_quad();
    logic [31:0] fr;
    fr = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 70000));
    return make_quad(random_fixed(), random_fixed(), random_fixed(), random_fixed(),
                     fr, 1'($urandom_range(0, 1)));
  endfunction

  // reset grid of one cell, field extremes
  task automatic test_default_grid();
    max_gap = 0;
    send_quad(make_quad(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    send_quad(make_quad(32'h0001_0000, 32'hffff_0000, 32'h0004_0000, 32'h0002_0000,
                        32'h0, 1'b1));
    send_quad(make_quad(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff, 1'b1));
    wait_idle();
  endtask

  // cell selection, frame wrap, zero and oversized grids, unused indexes
  task automatic test_grid_registers();
    max_gap = 5;
    write_grid(CFG_GRID_COLUMNS, 4);
    write_grid(CFG_GRID_ROWS, 3);
    send_quad(make_quad(32'h0010_0000, 32'h0020_0000, 32'h0008_0000, 32'h0008_0000,
                        32'd0, 1'b0));
    send_quad(make_quad(32'h0010_0000, 32'h0020_0000, 32'h0008_0000, 32'h0008_0000,
                        32'd5, 1'b1));
    send_quad(make_quad(32'h0010_0000, 32'h0020_0000, 32'h0008_0000, 32'h0008_0000,
                        32'd11, 1'b0));
    send_quad(make_quad(32'h0010_0000, 32'h0020_0000, 32'h0008_0000, 32'h0008_0000,
                        32'd12, 1'b0));
    wait_idle();
    // zero acts as one cell
    write_grid(CFG_GRID_COLUMNS, 0);
    write_grid(CFG_GRID_ROWS, 0);
    send_quad(make_quad(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd77, 1'b1));
    wait_idle();
    // above the grid limit acts as the limit
    write_grid(CFG_GRID_COLUMNS, 511);
    write_grid(CFG_GRID_ROWS, 300);
    send_quad(make_quad(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'hffff_ffff, 1'b0));
    send_quad(make_quad(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd65535, 1'b1));
    wait_idle();
    // writes to unused indexes leave the grid alone
    write_grid(CFG_GRID_COLUMNS, 3);
    write_grid(CFG_GRID_ROWS, 5);
    write_grid(CFG_NO_REG_2, 9'h1ff);
    write_grid(CFG_NO_REG_3, 9'h0);
    send_quad(make_quad(32'h0, 32'h0, 32'h0002_0000, 32'h0002_0000, 32'd13, 1'b0));
    wait_idle();
  endtask

  // position sums at and past the signed rails, odd and negative sizes
  task automatic test_position_saturation();
    max_gap = 3;
    write_grid(CFG_GRID_COLUMNS, 256);
    write_grid(CFG_GRID_ROWS, 256);
    send_quad(make_quad(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'd65535, 1'b0));
    send_quad(make_quad(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'd0, 1'b1));
    send_quad(make_quad(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'd255, 1'b0));
    send_quad(make_quad(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
                        32'd65280, 1'b1));
    send_quad(make_quad(32'h0000_0005, 32'hffff_fffb, 32'hffff_ffff, 32'h0000_0001,
                        32'h8000_0000, 1'b0));
    send_quad(make_quad(32'h7fff_0000, 32'h8000_ffff, 32'h0000_0003, 32'hffff_fffd,
                        32'h7fff_ffff, 1'b1));
    wait_idle();
  endtask

  // random sprites over several grid settings, some phases with no input gaps
  task automatic test_random_traffic();
    logic [CFG_W-1:0] cols, rows;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin cols = 256; rows = 256; end
        1: begin cols = 1;   rows = 256; end
        2: begin cols = 256; rows = 1;   end
        3: begin cols = 511; rows = 0;   end
        default: begin
          cols = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(0, 511);
          rows = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(0, 511);
        end
      endcase
      write_grid(CFG_GRID_COLUMNS, cols);
      write_grid(CFG_GRID_ROWS, rows);
      max_gap = (phase % 3 == 0) ? 0 : 5;
      repeat (17) send_quad(random_quad());
      wait_idle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_grid();
    test_grid_registers();
    test_position_saturation();
    test_random_traffic();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_vertices.size() != 0) begin
      errors++;
      $display("%0t: vertices never arrived, expected %0d more, actual 0",
               $time, pending_vertices.size());
    end
    $display("sent %0d sprite quads over %0d grid register writes", quads_sent, grid_writes);
    $display("compared %0d vertices, %0d mismatches", vertices_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ssqg_pkg.sv
hw/rtl/ssqg_rem_div.sv
hw/rtl/ssqg_frac_div.sv
hw/rtl/ssqg_vtx_emit.sv
hw/rtl/sprite_sheet_quad_generator.sv
sim/sprite_sheet_quad_generator_test.sv
